/* src/life_pkg.sv */
// Shared constants, result record and rule function for the Life stream block.
`timescale 1ns / 1ps

package life_pkg;

  // Grid bounds and the field widths that follow from them.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  // The row counter runs two rows past the grid while the last results drain.
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int DIM_W      = 9;
  localparam int OUT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  // Input item kinds.
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Neighbor counts that give a birth, and that let a live cell survive.
  localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

  // One emitted cell.
  typedef struct packed {
    logic             next_alive;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] column;
    logic             last;
  } result_t;

  // Rule B3/S23 for one cell.
  function automatic logic life_rule(logic center, logic [CNT_W-1:0] count);
    return (count == BIRTH_COUNT) || (center && (count == SURVIVE_COUNT));
  endfunction

endpackage

/* src/life_cellular_automaton_stream.sv */
// Streaming next-generation engine for Conway's Life, rule B3/S23.
`timescale 1ns / 1ps

// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid_i, in_stall_o, kind_i, alive_i   | in
// output   | out_valid_o, out_stall_i, next_alive_o,   | out
//          | row_o, column_o, last_o                   |
// config   | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//          | cfg_data_i                                |
//
// One input transfer is taken per cycle unless stalled; its result, if any, is
// registered in the output or skid register one row plus one cell behind the input.
// The column line store is read through a register addressed with the next column.
// A skid register takes a result while the output waits; the input stalls
// only while the skid register is full.
// Reset sets sizes to 64, clears positions, window, valids; line store needs none.

module life_cellular_automaton_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input cells
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic                            alive_i,
  // Results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            next_alive_o,
  output logic [7:0]                      row_o,
  output logic [7:0]                      column_o,
  output logic                            last_o,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [life_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [life_pkg::DIM_W-1:0]      cfg_data_i
);

  import life_pkg::*;

  // Clamped grid size minus one.
  logic [COL_W-1:0] wm1_q, wm1_d;
  logic [ROW_W-1:0] hm1_q, hm1_d;

  // Raster position and 3x3 window.
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [8:0]       window_q, window_d;

  // Line store: bit 1 is the upper row, bit 0 the middle row.
  logic [1:0]       line_mem [MAX_WIDTH];
  logic [1:0]       rd_q;
  logic [1:0]       wr_data;
  logic             wr_en;

  // Result register and skid register.
  logic             out_valid_q, skid_valid_q;
  result_t          out_q, skid_q;

  logic             in_xfer, out_xfer, cfg_wr, cfg_hit;
  logic             alive_in, up, md;
  logic [8:0]       win_base, win_new;
  logic             emit_row_end, emit_inner, emit, restart;
  logic             c1, c2;
  logic [CNT_W-1:0] n1, n2;
  result_t          res;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && ((cfg_index_i == CFG_GRID_WIDTH) ||
                                  (cfg_index_i == CFG_GRID_HEIGHT));
  assign in_stall_o  = skid_valid_q;

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = out_q.next_alive;
  assign row_o        = out_q.row;
  assign column_o     = out_q.column;
  assign last_o       = out_q.last;

  // Clamp register writes to 1..MAX and keep the size minus one.
  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_wr && cfg_index_i == CFG_GRID_WIDTH) begin
      if (cfg_data_i == '0) begin
        wm1_d = '0;
      end else if (32'(cfg_data_i) > MAX_WIDTH) begin
        wm1_d = COL_W'(MAX_WIDTH - 1);
      end else begin
        wm1_d = COL_W'(cfg_data_i - 1'b1);
      end
    end
    if (cfg_wr && cfg_index_i == CFG_GRID_HEIGHT) begin
      if (cfg_data_i == '0) begin
        hm1_d = '0;
      end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
        hm1_d = ROW_W'(MAX_HEIGHT - 1);
      end else begin
        hm1_d = ROW_W'(cfg_data_i - 1'b1);
      end
    end
  end

  // Window update and rule evaluation for the current item.
  always_comb begin
    alive_in = (kind_i == KIND_CELL) && (in_row_q <= hm1_q) && alive_i;
    up       = (in_row_q >= ROW_W'(2)) && rd_q[1];
    md       = (in_row_q >= ROW_W'(1)) && rd_q[0];

    // At the start of a row, the previous row's last cell is complete.
    emit_row_end = (in_col_q == '0) && (in_row_q >= ROW_W'(2));
    c1 = window_q[7];
    n1 = CNT_W'($countones(window_q & 9'h1F8)) - CNT_W'(c1);

    win_base = (in_col_q == '0) ? '0 : window_q;
    win_new  = {alive_in, md, up, win_base[8:3]};

    emit_inner = (in_col_q != '0) && (in_row_q >= ROW_W'(1));
    c2 = win_new[4];
    n2 = CNT_W'($countones(win_new)) - CNT_W'(c2);

    emit = emit_row_end || emit_inner;
    if (emit_row_end) begin
      res.next_alive = life_rule(c1, n1);
      res.row        = OUT_W'(in_row_q - ROW_W'(2));
      res.column     = OUT_W'(wm1_q);
      res.last       = (in_row_q == hm1_q + ROW_W'(2));
    end else begin
      res.next_alive = life_rule(c2, n2);
      res.row        = OUT_W'(in_row_q - ROW_W'(1));
      res.column     = OUT_W'(in_col_q - COL_W'(1));
      res.last       = 1'b0;
    end

    wr_en   = in_xfer;
    wr_data = {rd_q[0], alive_in};
    // A real register write or the last result's input starts a new generation.
    restart = cfg_hit || (in_xfer && emit && res.last);
  end

  // Next raster position.
  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    window_d = window_q;
    if (in_xfer) begin
      window_d = win_new;
      if (in_col_q == wm1_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end
    if (restart) begin
      in_col_d = '0;
      in_row_d = '0;
      window_d = '0;
    end
  end

  // Line store with the read of the next column registered ahead of its use.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[in_col_q] <= wr_data;
    end
    if (wr_en && in_col_q == in_col_d) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= line_mem[in_col_d];
    end
  end

  // Control state and size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q    <= COL_W'(63);
      hm1_q    <= ROW_W'(63);
      in_col_q <= '0;
      in_row_q <= '0;
      window_q <= '0;
    end else begin
      wm1_q    <= wm1_d;
      hm1_q    <= hm1_d;
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      window_q <= window_d;
    end
  end

  // Result valids: the skid register holds a result while the output waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_xfer) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_xfer && emit) begin
        if (out_valid_q && !out_xfer) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer && emit) begin
      if (out_valid_q && !out_xfer) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule
